@@ hw/rtl/spu_pkg.sv @@
// ----------------------------------------------------------------------------
// spu_pkg: shared types and constants of the spectrogram phase unwrapper
// Operation codes, controller/datapath interface structs, Q15.16 constants
// and the small arithmetic helpers used by the datapath.
// ----------------------------------------------------------------------------
package spu_pkg;

    // Number of bins held in the across-columns state memory
    localparam int BINS     = 512;
    localparam int BIN_AW   = $clog2(BINS);

    // Field widths
    localparam int PHASE_W  = 16;
    localparam int BIN_W    = 9;
    localparam int OUT_W    = 32;
    localparam int IN_TDATA_W = 32;

    // Internal arithmetic width: headroom for value + offset + search step
    localparam int W        = 36;

    // 2*pi in Q15.16, rounded to nearest
    localparam logic signed [W-1:0] TWO_PI  = 36'sd411775;

    // Highest power-of-two step exponent of the step search
    localparam int SRCH_TOP = 13;
    localparam int J_W      = $clog2(SRCH_TOP + 1);

    localparam logic signed [W-1:0] SAT_MAX = 36'sh0_7FFF_FFFF;
    localparam logic signed [W-1:0] SAT_MIN = 36'shF_8000_0000;

    // Configuration register indexes
    localparam logic REG_ACROSS = 1'b0;
    localparam logic REG_ALONG  = 1'b1;

    // Datapath operations, one per cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_LOAD_A,
        OP_LOAD_B,
        OP_ADD_OFF,
        OP_CHECK,
        OP_SEARCH,
        OP_LAST,
        OP_COMMIT_A,
        OP_COMMIT_B,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic bin_ok;    // incoming bin lies inside the state memory
        logic v_ge_p;    // value already at or above previous
        logic v_t_ge_p;  // one 2*pi step reaches previous
        logic j_zero;    // search is at its last exponent
        logic out_free;  // output register can take a result
    } t_stat;

    // Clamp a wide value into the signed 32-bit range
    function automatic logic signed [OUT_W-1:0] sat32(input logic signed [W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[OUT_W-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[OUT_W-1:0];
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

    // Sign-extend a 32-bit value to the internal width
    function automatic logic signed [W-1:0] ext(input logic signed [OUT_W-1:0] x);
        return {{(W-OUT_W){x[OUT_W-1]}}, x};
    endfunction

    // Start of a run: raise by 2*pi until not negative (at most two steps here)
    function automatic logic signed [W-1:0] start_prev(input logic signed [W-1:0] x);
        logic signed [W-1:0] x1;
        logic signed [W-1:0] x2;
        logic signed [W-1:0] r;
        x1 = x + TWO_PI;
        x2 = x1 + TWO_PI;
        if (x >= 0) begin
            r = x;
        end else if (x1 >= 0) begin
            r = x1;
        end else begin
            r = x2;
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/spectrogram_phase_unwrap.sv @@
// ----------------------------------------------------------------------------
// spectrogram_phase_unwrap: streaming two-pass phase unwrapper
// Unwraps Q3.12 spectrogram phase across columns per bin and down each
// column, producing one saturated Q15.16 result per sample.
//
//   Channel   Dir   Handshake                 Content
//   s_axis    in    tvalid/tready             tdata: phase, bin; tuser: first_column
//   m_axis    out   tvalid/tready             tdata: unwrapped_phase
//   apb       in    psel/penable/pwrite       0x0 across enable, 0x4 along enable
//
// One sample at a time. A sample is accepted and output; each enabled pass
// loads, adds the offset, checks and commits when the value needs at most one
// 2*pi step, and a larger gap adds a power-of-two step search and a final step.
// The per-bin state memory is read at accept and written at the end of the across pass.
// Reset is synchronous; the state memory is not cleared. A stalled output
// holds its register while the next sample is already being worked on.
// ----------------------------------------------------------------------------
module spectrogram_phase_unwrap (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] phase, [24:16] bin, [31:25] zero
    input  logic        s_axis_tuser,   // [0] first_column
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] unwrapped_phase
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic r_across_en;
    logic r_along_en;
    logic reg_sel;

    spu_pkg::t_cmd  cmd;
    spu_pkg::t_stat stat;

    assign reg_sel = paddr[2];
    assign pready  = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_across_en <= 1'b0;
            r_along_en  <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (reg_sel)
                spu_pkg::REG_ACROSS: r_across_en <= pwdata[0];
                spu_pkg::REG_ALONG:  r_along_en  <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // Register readback
    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            spu_pkg::REG_ACROSS: prdata[0] = r_across_en;
            spu_pkg::REG_ALONG:  prdata[0] = r_along_en;
            default: begin
            end
        endcase
    end

    spu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_across_en (r_across_en),
        .i_along_en  (r_along_en),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    spu_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (s_axis_tdata),
        .i_in_first  (s_axis_tuser),
        .o_out_data  (m_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready)
    );

endmodule

@@ hw/rtl/spu_ctrl.sv @@
// ----------------------------------------------------------------------------
// spu_ctrl: sequencer of the phase unwrapper
// Steps one sample through the across-columns and along-column passes and
// issues one datapath operation per cycle, except while waiting for input or output.
// ----------------------------------------------------------------------------
module spu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_across_en,
    input  logic          i_along_en,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  spu_pkg::t_stat i_stat,
    output spu_pkg::t_cmd  o_cmd
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_LOAD_A   = 9'b000000010,
        ST_LOAD_B   = 9'b000000100,
        ST_ADD_OFF  = 9'b000001000,
        ST_CHECK    = 9'b000010000,
        ST_SEARCH   = 9'b000100000,
        ST_LAST     = 9'b001000000,
        ST_COMMIT   = 9'b010000000,
        ST_OUT      = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_pass_b, n_pass_b;   // 0: across-columns pass, 1: along-column pass

    // State and pass register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pass_b <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pass_b <= n_pass_b;
        end
    end

    // Next state and operation select
    always_comb begin
        n_state    = r_state;
        n_pass_b   = r_pass_b;
        o_cmd.op   = spu_pkg::OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = spu_pkg::OP_ACCEPT;
                    if (i_across_en && i_stat.bin_ok) begin
                        n_state  = ST_LOAD_A;
                        n_pass_b = 1'b0;
                    end else if (i_along_en) begin
                        n_state  = ST_LOAD_B;
                        n_pass_b = 1'b1;
                    end else begin
                        n_state  = ST_OUT;
                    end
                end
            end
            ST_LOAD_A: begin
                o_cmd.op = spu_pkg::OP_LOAD_A;
                n_state  = ST_ADD_OFF;
            end
            ST_LOAD_B: begin
                o_cmd.op = spu_pkg::OP_LOAD_B;
                n_state  = ST_ADD_OFF;
            end
            ST_ADD_OFF: begin
                o_cmd.op = spu_pkg::OP_ADD_OFF;
                n_state  = ST_CHECK;
            end
            ST_CHECK: begin
                o_cmd.op = spu_pkg::OP_CHECK;
                if (i_stat.v_ge_p || i_stat.v_t_ge_p) begin
                    n_state = ST_COMMIT;
                end else begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                o_cmd.op = spu_pkg::OP_SEARCH;
                if (i_stat.j_zero) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: begin
                o_cmd.op = spu_pkg::OP_LAST;
                n_state  = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (r_pass_b) begin
                    o_cmd.op = spu_pkg::OP_COMMIT_B;
                    n_state  = ST_OUT;
                end else begin
                    o_cmd.op = spu_pkg::OP_COMMIT_A;
                    if (i_along_en) begin
                        n_state  = ST_LOAD_B;
                        n_pass_b = 1'b1;
                    end else begin
                        n_state  = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                // hold until the output register frees up
                if (i_stat.out_free) begin
                    o_cmd.op = spu_pkg::OP_OUT;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/spu_dpath.sv @@
// ----------------------------------------------------------------------------
// spu_dpath: datapath of the phase unwrapper
// Holds the working value, previous value and offset, the per-bin state
// memory, the along-column state and the output register.
// ----------------------------------------------------------------------------
module spu_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  spu_pkg::t_cmd                 i_cmd,
    output spu_pkg::t_stat                o_stat,
    input  logic [spu_pkg::IN_TDATA_W-1:0] i_in_data,
    input  logic                          i_in_first,
    output logic [spu_pkg::OUT_W-1:0]     o_out_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready
);

    function automatic logic signed [spu_pkg::PHASE_W-1:0] in_data_phase(
        input logic [spu_pkg::IN_TDATA_W-1:0] d);
        return d[spu_pkg::PHASE_W-1:0];
    endfunction

    // Input fields
    logic signed [spu_pkg::PHASE_W-1:0] in_phase;
    logic [spu_pkg::BIN_W-1:0]          in_bin;
    logic signed [spu_pkg::OUT_W-1:0]   in_q16;

    assign in_phase = in_data_phase(i_in_data);
    assign in_bin   = i_in_data[spu_pkg::PHASE_W +: spu_pkg::BIN_W];
    // Q3.12 to Q15.16: multiply by 16
    assign in_q16   = {{(spu_pkg::OUT_W-spu_pkg::PHASE_W-4){in_phase[spu_pkg::PHASE_W-1]}},
                       in_phase, 4'b0000};

    // Working registers
    logic signed [spu_pkg::OUT_W-1:0] r_x;       // pass input / result
    logic [spu_pkg::BIN_W-1:0]        r_bin;
    logic                             r_first;
    logic signed [spu_pkg::W-1:0]     r_v;
    logic signed [spu_pkg::W-1:0]     r_p;
    logic signed [spu_pkg::W-1:0]     r_f;
    logic [spu_pkg::J_W-1:0]          r_j;
    logic signed [spu_pkg::OUT_W-1:0] r_col_prev;
    logic signed [spu_pkg::OUT_W-1:0] r_col_off;
    logic [2*spu_pkg::OUT_W-1:0]      r_rd;
    logic [spu_pkg::OUT_W-1:0]        r_out_data;
    logic                             r_out_valid;

    // Per-bin state memory: previous value in the upper half, offset below
    logic [2*spu_pkg::OUT_W-1:0] mem [spu_pkg::BINS];

    logic signed [spu_pkg::W-1:0]     v_t;
    logic signed [spu_pkg::W-1:0]     step;
    logic signed [spu_pkg::W-1:0]     v_step;
    logic signed [spu_pkg::OUT_W-1:0] v_sat;
    logic signed [spu_pkg::OUT_W-1:0] f_sat;
    logic signed [spu_pkg::W-1:0]     x_ext;
    logic signed [spu_pkg::W-1:0]     mem_prev;
    logic signed [spu_pkg::W-1:0]     mem_off;

    assign v_t      = r_v + spu_pkg::TWO_PI;
    assign step     = spu_pkg::TWO_PI <<< r_j;
    assign v_step   = r_v + step;
    assign v_sat    = spu_pkg::sat32(r_v);
    assign f_sat    = spu_pkg::sat32(r_f);
    assign x_ext    = spu_pkg::ext(r_x);
    assign mem_prev = spu_pkg::ext(r_rd[2*spu_pkg::OUT_W-1:spu_pkg::OUT_W]);
    assign mem_off  = spu_pkg::ext(r_rd[spu_pkg::OUT_W-1:0]);

    // Status toward the controller
    assign o_stat.bin_ok   = ({{(32-spu_pkg::BIN_W){1'b0}}, in_bin} < 32'(spu_pkg::BINS));
    assign o_stat.v_ge_p   = (r_v >= r_p);
    assign o_stat.v_t_ge_p = (v_t >= r_p);
    assign o_stat.j_zero   = (r_j == '0);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    // State memory: read at accept, write back at the end of the across pass
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == spu_pkg::OP_ACCEPT) begin
            r_rd <= mem[in_bin[spu_pkg::BIN_AW-1:0]];
        end
        if (i_cmd.op == spu_pkg::OP_COMMIT_A) begin
            mem[r_bin[spu_pkg::BIN_AW-1:0]] <= {v_sat, f_sat};
        end
    end

    // Working value, previous value, offset and search exponent
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            spu_pkg::OP_ACCEPT: begin
                r_x     <= in_q16;
                r_bin   <= in_bin;
                r_first <= i_in_first;
            end
            spu_pkg::OP_LOAD_A: begin
                r_v <= x_ext;
                if (r_first) begin
                    r_p <= spu_pkg::start_prev(x_ext);
                    r_f <= '0;
                end else begin
                    r_p <= mem_prev;
                    r_f <= mem_off;
                end
            end
            spu_pkg::OP_LOAD_B: begin
                r_v <= x_ext;
                if (r_bin == '0) begin
                    r_p <= spu_pkg::start_prev(x_ext);
                    r_f <= '0;
                end else begin
                    r_p <= spu_pkg::ext(r_col_prev);
                    r_f <= spu_pkg::ext(r_col_off);
                end
            end
            spu_pkg::OP_ADD_OFF: begin
                if (r_v < r_p) begin
                    r_v <= r_v + r_f;
                end
            end
            spu_pkg::OP_CHECK: begin
                // one step closes most gaps; otherwise start the step search
                if (r_v < r_p) begin
                    if (v_t >= r_p) begin
                        r_v <= v_t;
                        r_f <= r_f + spu_pkg::TWO_PI;
                    end
                end
                r_j <= spu_pkg::J_W'(spu_pkg::SRCH_TOP);
            end
            spu_pkg::OP_SEARCH: begin
                // take the power-of-two step if it stays below previous
                if (v_step < r_p) begin
                    r_v <= v_step;
                    r_f <= r_f + step;
                end
                if (r_j != '0) begin
                    r_j <= r_j - 1'b1;
                end
            end
            spu_pkg::OP_LAST: begin
                r_v <= v_t;
                r_f <= r_f + spu_pkg::TWO_PI;
            end
            spu_pkg::OP_COMMIT_A: begin
                r_x <= v_sat;
            end
            spu_pkg::OP_COMMIT_B: begin
                r_x <= v_sat;
            end
            spu_pkg::OP_NONE, spu_pkg::OP_OUT: begin
            end
            default: begin
            end
        endcase
    end

    // Along-column state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_prev <= '0;
            r_col_off  <= '0;
        end else if (i_cmd.op == spu_pkg::OP_COMMIT_B) begin
            r_col_prev <= v_sat;
            r_col_off  <= f_sat;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == spu_pkg::OP_OUT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == spu_pkg::OP_OUT) begin
            r_out_data <= r_x;
        end
    end

    assign o_out_data  = r_out_data;
    assign o_out_valid = r_out_valid;

endmodule

@@ tb/tb_spectrogram_phase_unwrap.sv @@
// ----------------------------------------------------------------------------
// tb_spectrogram_phase_unwrap: self-checking bench for the phase unwrapper
// Streams Q3.12 phase requests through the block under every enable setting
// and compares each Q15.16 result with a bit-exact behavioral predictor. The
// sender bursts and idles, and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_spectrogram_phase_unwrap;

    localparam int     CLK_HALF        = 5;
    localparam int     RESET_CYCLES    = 9;
    localparam longint STEP_2PI        = 411775;   // 2*pi in Q15.16
    localparam int     PI_Q12          = 12868;
    localparam int     TWO_PI_Q12      = 25736;
    localparam int     SETTLE_CYCLES   = 64;
    localparam int     MISMATCH_PRINTS = 10;
    localparam int     RANDOM_SAMPLES  = 1000;
    localparam int     SAT_COLUMNS     = 100;
    localparam int     PENDING_DEPTH   = 16;
    localparam int     TIMEOUT_NS      = 12_000_000;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_CHOKE
    } t_rx_pattern;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [15:0] phase, [24:16] bin, [31:25] zero
    logic        s_axis_tuser;   // [0] first_column
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] unwrapped_phase
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state
    bit          across_on;
    bit          along_on;
    int          across_prev [spu_pkg::BINS];
    int          across_off  [spu_pkg::BINS];
    bit          across_written [spu_pkg::BINS];
    int          along_prev;
    int          along_off;

    // Stimulus state
    logic [31:0] pending_unwrapped [PENDING_DEPTH];
    int          pending_wr;
    int          pending_rd;
    int          walk_phase [spu_pkg::BINS];
    int          burst_left;
    int          samples_sent;
    bit          steady;
    int          mismatch_count;
    logic [31:0] want_phase;

    spectrogram_phase_unwrap DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Number of 2*pi steps that lift v to at least p
    function automatic longint lift_steps(input longint v, input longint p);
        if (v >= p) begin
            return 0;
        end
        return (p - v + STEP_2PI - 1) / STEP_2PI;
    endfunction

    function automatic int clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return int'(v);
    endfunction

    // One unwrap pass; a run start seeds previous from the value itself
    function automatic int unwrap_pass(input int x, input bit start,
                                       inout int prev, inout int off);
        longint v;
        longint p;
        longint f;
        longint k;
        v = x;
        if (start) begin
            p = v + lift_steps(v, 0) * STEP_2PI;
            f = 0;
        end else begin
            p = prev;
            f = off;
        end
        if (v < p) begin
            v += f;
        end
        k = lift_steps(v, p);
        v += k * STEP_2PI;
        f += k * STEP_2PI;
        prev = clamp32(v);
        off  = clamp32(f);
        return clamp32(v);
    endfunction

    function automatic logic [31:0] predict_unwrapped(input logic [15:0] ph,
                                                      input logic [8:0] bn,
                                                      input bit first);
        shortint raw;
        int      v;
        int      p;
        int      f;
        raw = ph;
        v   = raw * 16;
        if (across_on && bn < spu_pkg::BINS) begin
            p = across_prev[bn];
            f = across_off[bn];
            v = unwrap_pass(v, first, p, f);
            across_prev[bn]    = p;
            across_off[bn]     = f;
            across_written[bn] = 1'b1;
        end
        if (along_on) begin
            v = unwrap_pass(v, bn == 0, along_prev, along_off);
        end
        return v;
    endfunction

    // Ring of predictions waiting for their results
    function automatic void pending_put(input logic [31:0] val);
        pending_unwrapped[pending_wr % PENDING_DEPTH] = val;
        pending_wr++;
    endfunction

    function automatic logic [31:0] pending_take();
        logic [31:0] val;
        val = pending_unwrapped[pending_rd % PENDING_DEPTH];
        pending_rd++;
        return val;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    function automatic void note_mismatch(input string what, input logic [31:0] exp_v,
                                          input logic [31:0] got_v);
        mismatch_count++;
        if (mismatch_count <= MISMATCH_PRINTS) begin
            $display("%0t mismatch, %s: expected %h, got %h", $time, what, exp_v, got_v);
        end
    endfunction

    // Compare every accepted result with the oldest pending prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_wr == pending_rd) begin
                note_mismatch("result with nothing pending", 32'hx, m_axis_tdata);
            end else begin
                want_phase = pending_take();
                if (m_axis_tdata !== want_phase) begin
                    note_mismatch("unwrapped_phase", want_phase, m_axis_tdata);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver stall pattern
    // ------------------------------------------------------------------------
    initial begin
        t_rx_pattern pattern;
        int          span;
        int          j;
        m_axis_tready = 1'b0;
        forever begin
            pattern = t_rx_pattern'($urandom_range(0, 3));
            span    = $urandom_range(8, 120);
            for (j = 0; j < span; j++) begin
                @(negedge i_clk);
                if (steady) begin
                    m_axis_tready <= 1'b1;
                end else begin
                    case (pattern)
                        RX_OPEN:   m_axis_tready <= 1'b1;
                        RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                        RX_SPARSE: m_axis_tready <= (j % 4) == 0;
                        default:   m_axis_tready <= (j % 32) >= 24;
                    endcase
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Send one phase request; starts and ends at a falling edge
    task automatic send_sample(input logic [15:0] ph, input logic [8:0] bn, input bit first);
        int gap;
        // never let the across pass read a bin that was never written
        if (across_on && !first && !across_written[bn]) begin
            first = 1'b1;
        end
        if (burst_left == 0) begin
            gap        = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, bn, ph};
        s_axis_tuser  <= first;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_put(predict_unwrapped(ph, bn, first));
        samples_sent++;
        @(negedge i_clk);
    endtask

    // Stop sending and hold until every pending result has come back
    task automatic drain_results;
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_wr != pending_rd) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    // Write one enable register, then read it back
    task automatic set_reg(input logic idx, input bit val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {31'b0, val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == spu_pkg::REG_ACROSS) begin
            across_on = val;
        end else begin
            along_on = val;
        end
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {31'b0, val}) begin
            note_mismatch(idx == spu_pkg::REG_ACROSS ? "across enable readback" :
                          "along enable readback", {31'b0, val}, prdata);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_enables(input bit across, input bit along);
        set_reg(spu_pkg::REG_ACROSS, across);
        set_reg(spu_pkg::REG_ALONG, along);
    endtask

    // Mostly a wrapped random walk per bin, sometimes any 16-bit value
    function automatic logic [15:0] next_phase(input int b);
        int p;
        if ($urandom_range(0, 3) == 0) begin
            return 16'($urandom);
        end
        p = walk_phase[b] + int'($urandom_range(0, 12000)) - 6000;
        if (p >= PI_Q12) begin
            p -= TWO_PI_Q12;
        end else if (p < -PI_Q12) begin
            p += TWO_PI_Q12;
        end
        walk_phase[b] = p;
        return p[15:0];
    endfunction

    // Columns of consecutive bins; fresh marks the first column as the oldest
    task automatic send_frame(input int ncols, input int first_bin, input int nbins,
                              input bit fresh);
        int c;
        int b;
        for (c = 0; c < ncols; c++) begin
            for (b = first_bin; b < first_bin + nbins && b < spu_pkg::BINS; b++) begin
                send_sample(next_phase(b), b[8:0], fresh && c == 0);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Both passes off: plain Q3.12 to Q15.16 conversion
    task automatic test_passthrough;
        set_enables(1'b0, 1'b0);
        send_sample(16'h7FFF, 9'd0,   1'b1);
        send_sample(16'h8000, 9'd511, 1'b0);
        send_sample(16'h0000, 9'h155, 1'b1);
        send_sample(16'hFFFF, 9'h0AA, 1'b0);
        send_sample(16'h5555, 9'd1,   1'b0);
        send_sample(16'hAAAA, 9'd256, 1'b1);
        drain_results();
    endtask

    // Across pass alone: run starts, wraps down, multi-step lifts
    task automatic test_across_columns;
        set_enables(1'b1, 1'b0);
        send_sample(16'h8000, 9'd0, 1'b1);
        send_sample(16'hF000, 9'd1, 1'b1);
        send_sample(16'h1000, 9'd2, 1'b1);
        send_sample(16'h7FFF, 9'd0, 1'b0);
        send_sample(16'h8000, 9'd1, 1'b0);
        send_sample(16'h0800, 9'd2, 1'b0);
        send_sample(16'h8000, 9'd0, 1'b0);
        send_frame(4, 0, 6, 1'b1);
        drain_results();
    endtask

    // Along pass alone, starting mid-column on the state left from reset
    task automatic test_along_column;
        set_enables(1'b0, 1'b1);
        send_sample(16'h9000, 9'd3, 1'b0);
        send_sample(16'h7000, 9'd4, 1'b0);
        send_sample(16'h8000, 9'd0, 1'b0);
        send_sample(16'h8000, 9'd1, 1'b0);
        send_sample(16'h7FFF, 9'd2, 1'b0);
        send_sample(16'h8001, 9'd3, 1'b0);
        send_frame(3, 0, 8, 1'b0);
        drain_results();
    endtask

    task automatic test_both_passes;
        set_enables(1'b1, 1'b1);
        send_frame(5, 0, 6, 1'b1);
        send_frame(2, 0, 40, 1'b0);
        drain_results();
    endtask

    // Flip enables between samples of one column while keeping the state
    task automatic test_enable_toggle;
        set_enables(1'b1, 1'b1);
        send_frame(1, 0, 4, 1'b1);
        drain_results();
        set_reg(spu_pkg::REG_ALONG, 1'b0);
        send_frame(1, 4, 4, 1'b1);
        drain_results();
        set_enables(1'b0, 1'b1);
        send_frame(1, 0, 8, 1'b0);
        drain_results();
        set_reg(spu_pkg::REG_ACROSS, 1'b1);
        send_frame(2, 0, 8, 1'b0);
        drain_results();
    endtask

    // Bin 1 climbs across columns while bin 2 stays put; without bin 0 the
    // along offset takes the growing gap every column until it saturates
    task automatic test_saturation;
        int n;
        steady = 1'b1;
        set_enables(1'b1, 1'b1);
        for (n = 0; n < SAT_COLUMNS; n++) begin
            send_sample(n[0] ? 16'h8000 : 16'h7FFF, 9'd1, n == 0);
            send_sample(16'h8000, 9'd2, n == 0);
        end
        drain_results();
        steady = 1'b0;
    endtask

    // Mostly well-formed frames, some broken columns and pure noise
    task automatic test_random_traffic;
        int start_count;
        int n;
        int nbins;
        start_count = samples_sent;
        while (samples_sent - start_count < RANDOM_SAMPLES) begin
            if ($urandom_range(0, 4) == 0) begin
                drain_results();
                set_enables(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 7) == 0) begin
                for (n = $urandom_range(1, 6); n > 0; n--) begin
                    send_sample(16'($urandom), 9'($urandom_range(0, spu_pkg::BINS - 1)),
                                1'($urandom_range(0, 1)));
                end
            end else begin
                nbins = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 64)
                                                     : $urandom_range(1, 12);
                send_frame($urandom_range(1, 5),
                           ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0,
                           nbins, $urandom_range(0, 2) == 0);
            end
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        across_on     = 1'b0;
        along_on      = 1'b0;
        along_prev    = 0;
        along_off     = 0;
        pending_wr    = 0;
        pending_rd    = 0;
        burst_left    = 0;
        samples_sent  = 0;
        steady        = 1'b0;
        mismatch_count = 0;
        foreach (across_prev[b]) begin
            across_prev[b]    = 0;
            across_off[b]     = 0;
            across_written[b] = 1'b0;
            walk_phase[b]     = 0;
        end
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_passthrough();
        test_across_columns();
        test_along_column();
        test_both_passes();
        test_enable_toggle();
        test_saturation();
        test_random_traffic();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/spu_pkg.sv
hw/rtl/spu_ctrl.sv
hw/rtl/spu_dpath.sv
hw/rtl/spectrogram_phase_unwrap.sv
tb/tb_spectrogram_phase_unwrap.sv
